// ===== sv/ced_pkg.sv =====
// -----------------------------------------------------------------------------
// ced_pkg - shared types and constants for the character edit distance block
// Operation codes, sequencer states and result field widths.
// -----------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

  localparam int DIST_W = 7;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LEFT   = 2'd0;
  localparam logic [OP_W-1:0] OP_RIGHT  = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_CELL  = 4'b0100,
    ST_FIN   = 4'b1000
  } ced_state_t;

endpackage

`default_nettype wire

// ===== sv/char_edit_distance.sv =====
// -----------------------------------------------------------------------------
// char_edit_distance - Levenshtein distance between two character strings
// Left characters fill a store; each right character sweeps one table row
// through a single compare/min/increment unit; finish emits the distance.
// -----------------------------------------------------------------------------
// Timing: a left character, a dropped word or an unused op is taken in the idle
// state without leaving it. A right character goes through a prime state for
// the memory reads, then walks the row one cell per cycle through the single
// cell unit, with one read and one write of the row memory per cell; it stays
// idle when the left string is empty. A finish word goes through the finish
// state, which waits while the previous result is still held by out_stall.
// in_stall is high while the block is out of idle. No clearing pass is needed
// after reset or finish: the first row is seeded from the column index rather than from memory.
`default_nettype none

module char_edit_distance #(
  parameter int MAX_LEN    = 64,
  parameter int CHAR_WIDTH = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ced_pkg::OP_W-1:0]    in_op,
  input  wire logic [CHAR_WIDTH-1:0]       in_char_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ced_pkg::DIST_W-1:0]       out_distance,
  output logic                             out_overflow
);

  import ced_pkg::*;

  localparam int DW   = $clog2(MAX_LEN + 1);
  localparam int SW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EXTW = DW + DIST_W;
  localparam logic [DW-1:0] MAX_CNT = DW'(MAX_LEN);
  localparam logic [DW-1:0] ONE     = DW'(1);

  // storage
  logic [CHAR_WIDTH-1:0] left_mem [MAX_LEN];
  logic [DW-1:0]         row_mem  [MAX_LEN+1];

  ced_state_t            state_r, state_nxt;
  logic [DW-1:0]         left_count_r, left_count_nxt;
  logic [DW-1:0]         right_count_r, right_count_nxt;
  logic                  overflow_r, overflow_nxt;
  logic [DW-1:0]         idx_r, idx_nxt;
  logic [DW-1:0]         diag_r, diag_nxt;
  logic [DW-1:0]         lft_r, lft_nxt;
  logic                  first_r, first_nxt;
  logic [CHAR_WIDTH-1:0] ch_r, ch_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]     out_distance_r, out_distance_nxt;
  logic                  out_overflow_r, out_overflow_nxt;

  logic                  accept;
  logic                  store_wr_en;
  logic                  row_wr_en;
  logic                  store_rd_en;
  logic                  row_rd_en;
  logic [SW-1:0]         store_rd_addr;
  logic [DW-1:0]         row_rd_addr;
  logic [CHAR_WIDTH-1:0] store_q;
  logic [DW-1:0]         row_q;

  logic [DW-1:0]         up;
  logic [DW-1:0]         min_a;
  logic [DW-1:0]         min_b;
  logic [DW-1:0]         cell_nv;
  logic                  last_cell;
  logic [DW-1:0]         dist_raw;
  logic [EXTW-1:0]       dist_ext;
  logic                  out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_cell = (idx_r == left_count_r);

  // cell unit: one table entry per use
  assign up      = first_r ? idx_r : row_q;
  assign min_a   = (up < lft_r) ? up : lft_r;
  assign min_b   = (min_a < diag_r) ? min_a : diag_r;
  assign cell_nv = (store_q == ch_r) ? diag_r : (min_b + ONE);

  // finish value: row entry zero and the untouched first row are not stored
  always_comb begin
    if (left_count_r == '0) begin
      dist_raw = right_count_r;
    end else if (right_count_r == '0) begin
      dist_raw = left_count_r;
    end else begin
      dist_raw = row_q;
    end
  end
  assign dist_ext = EXTW'(dist_raw);

  // memory ports
  assign store_wr_en = accept && (in_op == OP_LEFT) && (right_count_r == '0) &&
                       (left_count_r < MAX_CNT);
  assign row_wr_en   = (state_r == ST_CELL);

  always_comb begin
    store_rd_en   = 1'b0;
    row_rd_en     = 1'b0;
    store_rd_addr = '0;
    row_rd_addr   = left_count_r;
    case (state_r)
      ST_IDLE: begin
        row_rd_en = 1'b1;
      end
      ST_PRIME: begin
        store_rd_en = 1'b1;
        row_rd_en   = 1'b1;
        row_rd_addr = ONE;
      end
      ST_CELL: begin
        store_rd_en   = !last_cell;
        row_rd_en     = !last_cell;
        store_rd_addr = idx_r[SW-1:0];
        row_rd_addr   = idx_r + ONE;
      end
      default: begin
        store_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_wr_en) begin
      left_mem[left_count_r[SW-1:0]] <= in_char_value;
    end
    if (store_rd_en) begin
      store_q <= left_mem[store_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (row_wr_en) begin
      row_mem[idx_r] <= cell_nv;
    end
    if (row_rd_en) begin
      row_q <= row_mem[row_rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    left_count_nxt   = left_count_r;
    right_count_nxt  = right_count_r;
    overflow_nxt     = overflow_r;
    idx_nxt          = idx_r;
    diag_nxt         = diag_r;
    lft_nxt          = lft_r;
    first_nxt        = first_r;
    ch_nxt           = ch_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_distance_nxt = out_distance_r;
    out_overflow_nxt = out_overflow_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LEFT: begin
              if (right_count_r == '0) begin
                if (left_count_r < MAX_CNT) begin
                  left_count_nxt = left_count_r + ONE;
                end else begin
                  overflow_nxt = 1'b1;
                end
              end
            end
            OP_RIGHT: begin
              if (right_count_r >= MAX_CNT) begin
                overflow_nxt = 1'b1;
              end else if (left_count_r == '0) begin
                right_count_nxt = right_count_r + ONE;
              end else begin
                diag_nxt  = right_count_r;
                lft_nxt   = right_count_r + ONE;
                first_nxt = (right_count_r == '0);
                ch_nxt    = in_char_value;
                idx_nxt   = ONE;
                state_nxt = ST_PRIME;
              end
            end
            OP_FINISH: begin
              state_nxt = ST_FIN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_PRIME: begin
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        diag_nxt = up;
        lft_nxt  = cell_nv;
        if (last_cell) begin
          right_count_nxt = right_count_r + ONE;
          state_nxt       = ST_IDLE;
        end else begin
          idx_nxt = idx_r + ONE;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = (dist_ext > EXTW'(DIST_MAX)) ? DIST_MAX
                                                          : dist_ext[DIST_W-1:0];
          out_overflow_nxt = overflow_r;
          left_count_nxt   = '0;
          right_count_nxt  = '0;
          overflow_nxt     = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      left_count_r  <= '0;
      right_count_r <= '0;
      overflow_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      left_count_r  <= left_count_nxt;
      right_count_r <= right_count_nxt;
      overflow_r    <= overflow_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    diag_r         <= diag_nxt;
    lft_r          <= lft_nxt;
    first_r        <= first_nxt;
    ch_r           <= ch_nxt;
    out_distance_r <= out_distance_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

endmodule

`default_nettype wire

// ===== bench/char_edit_distance_tb.sv =====
// -----------------------------------------------------------------------------
// char_edit_distance_tb - self-checking bench for the edit distance block
// Streams left/right character words and finish words through the block with
// random idle gaps on both sides, tracks the distance row in a local copy and
// checks every emitted distance and overflow flag in order.
// -----------------------------------------------------------------------------
module char_edit_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ced_pkg::*;

  localparam int LEN_MAX  = 64;
  localparam int CW       = 31;
  localparam int WATCHDOG = 3000;
  localparam int HOLD_LEN = 400;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CW-1:0]   CHAR_ONES = '1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CW-1:0]   ch;
  } word_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              ovf;
  } dist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = OP_LEFT;
  logic [CW-1:0]     in_char_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance;
  logic              out_overflow;

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  char_edit_distance #(
    .MAX_LEN    (LEN_MAX),
    .CHAR_WIDTH (CW)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_char_value (in_char_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance  (out_distance),
    .out_overflow  (out_overflow)
  );

  always #10 clk = ~clk;

  word_t pending_words[$];
  dist_t dist_due[$];

  // Local copy of the distance table state
  logic [CW-1:0] left_chars [LEN_MAX];
  int            dist_row [LEN_MAX+1];
  int            n_left;
  int            n_right;
  logic          ovf_seen;

  int n_queued   = 0;
  int n_words    = 0;
  int n_rights   = 0;
  int n_checked  = 0;
  int n_ovf      = 0;
  int n_err      = 0;
  int tx_wait    = 0;
  int rx_wait    = 0;
  int hold_left  = 0;
  logic hold_used = 1'b0;
  int quiet      = 0;
  int calm_left [2] = '{0, 0};

  task automatic clear_pair();
    int i;
    for (i = 0; i <= LEN_MAX; i++) dist_row[i] = i;
    n_left   = 0;
    n_right  = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic track_word(logic [OP_W-1:0] op, logic [CW-1:0] ch);
    int    i;
    int    diag;
    int    up;
    int    nv;
    dist_t res;
    case (op)
      OP_LEFT: begin
        // drop left characters once the right string has started
        if (n_right == 0) begin
          if (n_left >= LEN_MAX) ovf_seen = 1'b1;
          else begin
            left_chars[n_left] = ch;
            n_left++;
          end
        end
      end
      OP_RIGHT: begin
        if (n_right >= LEN_MAX) ovf_seen = 1'b1;
        else begin
          diag        = dist_row[0];
          dist_row[0] = n_right + 1;
          for (i = 1; i <= n_left; i++) begin
            up = dist_row[i];
            if (left_chars[i-1] == ch) nv = diag;
            else begin
              nv = up + 1;
              if (dist_row[i-1] + 1 < nv) nv = dist_row[i-1] + 1;
              if (diag + 1 < nv) nv = diag + 1;
            end
            diag        = up;
            dist_row[i] = nv;
          end
          n_right++;
        end
      end
      OP_FINISH: begin
        res.distance = (dist_row[n_left] > DIST_MAX) ? DIST_MAX : DIST_W'(dist_row[n_left]);
        res.ovf      = ovf_seen;
        dist_due.push_back(res);
        clear_pair();
      end
      default: ;
    endcase
  endtask

  // Idle cycles before the next word; now and then a calm stretch with none
  function automatic int pick_wait(int side);
    if (calm_left[side] != 0) begin
      calm_left[side] = calm_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [CW-1:0] pick_char(logic [CW-1:0] base, int mode);
    if (mode < 6) return base ^ CW'($urandom_range(0, 3));
    if (mode < 8) return CW'($urandom);
    return ($urandom_range(0, 1) != 0) ? CHAR_ONES : '0;
  endfunction

  task automatic push_word(logic [OP_W-1:0] op, logic [CW-1:0] ch);
    word_t w;
    w.op = op;
    w.ch = ch;
    pending_words.push_back(w);
    if (op != OP_UNUSED) n_queued++;
  endtask

  task automatic queue_pair(int llen, int rlen);
    int            i;
    int            mode;
    logic [CW-1:0] base;
    mode = $urandom_range(0, 9);
    base = CW'($urandom);
    for (i = 0; i < llen; i++) push_word(OP_LEFT, pick_char(base, mode));
    for (i = 0; i < rlen; i++) push_word(OP_RIGHT, pick_char(base, mode));
    push_word(OP_FINISH, CW'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || dist_due.size() != 0)
      @(negedge clk);
  endtask

  // Input driver
  always @(posedge clk) begin : word_driver
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_fire) begin
        track_word(in_op, in_char_value);
        n_words++;
        if (in_op == OP_RIGHT) n_rights++;
      end
      if (!in_valid || in_fire) begin
        if (tx_wait != 0) begin
          in_valid <= 1'b0;
          tx_wait  <= tx_wait - 1;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_valid      <= 1'b1;
          in_op         <= w.op;
          in_char_value <= w.ch;
          tx_wait       <= pick_wait(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin : result_check
    int    w;
    dist_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else begin
      w = rx_wait;
      if (out_fire) begin
        if (dist_due.size() == 0) begin
          $error("unexpected result: distance %0d, overflow %0d", out_distance, out_overflow);
          n_err++;
        end else begin
          want = dist_due.pop_front();
          if (out_distance !== want.distance) begin
            $error("distance mismatch: expected %0d, got %0d", want.distance, out_distance);
            n_err++;
          end
          if (out_overflow !== want.ovf) begin
            $error("overflow mismatch: expected %0d, got %0d", want.ovf, out_overflow);
            n_err++;
          end
        end
        n_checked <= n_checked + 1;
        if (out_overflow) n_ovf <= n_ovf + 1;
        w = pick_wait(1);
      end else if (w != 0) begin
        w = w - 1;
      end
      rx_wait   <= w;
      out_stall <= (w != 0) || (hold_left != 0);
    end
  end

  // One long hold-off on the result side so the block backs up its input
  always @(posedge clk) begin
    if (!hold_used && n_checked >= 40) begin
      hold_left <= HOLD_LEN;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) quiet <= 0;
    else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG) begin
        $display("char_edit_distance_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int r;
    int k;
    int i;
    logic half_done;
    clear_pair();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // both strings empty
    push_word(OP_FINISH, CHAR_ONES);
    // empty right, empty left
    push_word(OP_LEFT, '0);
    push_word(OP_FINISH, '0);
    push_word(OP_RIGHT, CHAR_ONES);
    push_word(OP_FINISH, '0);
    // equal strings at the character extremes
    push_word(OP_LEFT, '0);
    push_word(OP_LEFT, CHAR_ONES);
    push_word(OP_RIGHT, '0);
    push_word(OP_RIGHT, CHAR_ONES);
    push_word(OP_FINISH, CHAR_ONES);
    // single substitution
    push_word(OP_LEFT, CHAR_ONES);
    push_word(OP_RIGHT, '0);
    push_word(OP_FINISH, '0);
    // unused op, then a left character after the right string has begun
    push_word(OP_UNUSED, CHAR_ONES);
    push_word(OP_LEFT, CW'(5));
    push_word(OP_RIGHT, CW'(5));
    push_word(OP_LEFT, CW'(9));
    push_word(OP_FINISH, '0);
    wait_drained();

    // too many characters on each side
    queue_pair(66, 2);
    queue_pair(3, 67);

    half_done = 1'b0;
    while (n_queued < 1250) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        if ($urandom_range(0, 1) != 0) queue_pair($urandom_range(65, 68), $urandom_range(0, 4));
        else queue_pair($urandom_range(0, 4), $urandom_range(65, 68));
      end else if (r < 6) begin
        queue_pair($urandom_range(20, 64), $urandom_range(1, 10));
      end else if (r < 9) begin
        queue_pair($urandom_range(0, 4), $urandom_range(20, 64));
      end else if (r < 90) begin
        queue_pair($urandom_range(0, 8), $urandom_range(0, 8));
      end else begin
        // noise: any op in any order, then close the pair
        k = $urandom_range(1, 12);
        for (i = 0; i < k; i++) push_word(OP_W'($urandom_range(0, 3)), CW'($urandom));
        push_word(OP_FINISH, CW'($urandom));
      end
      if (!half_done && n_queued >= 625) begin
        half_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    @(negedge clk);
    $display("%0d words accepted, %0d of them right characters", n_words, n_rights);
    $display("%0d distances checked, %0d with the overflow flag set", n_checked, n_ovf);
    if (n_err == 0 && dist_due.size() == 0) begin
      $display("char_edit_distance_tb: PASS");
    end else begin
      $display("char_edit_distance_tb: FAIL");
    end
    $finish;
  end

endmodule
